// ----- rtl/core/tsrd_pkg.sv -----
// ----------------------------------------------------------------------------
// tsrd_pkg: shared definitions for the thumbstick radial deadzone
// Field widths, register indices, sequencer states and small helpers.
// ----------------------------------------------------------------------------
package tsrd_pkg;

  localparam int PAD_COUNT_DEF = 4;

  localparam int DZ_W       = 15;
  localparam int AXIS_W     = 16;
  localparam int PAD_W      = 2;
  localparam int CFG_ADDR_W = 1;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_DZ  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_DZ = 1'b1;

  localparam logic [DZ_W-1:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [DZ_W-1:0] RIGHT_DZ_RST = 15'd8689;
  localparam logic [DZ_W-1:0] FULL_SCALE   = 15'd32767;

  localparam logic [23:0] CAP_MAX   = 24'h7FFF00;
  localparam logic [47:0] ROOT_BIT0 = 48'h4000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISC,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_DZ,
    ST_CMP,
    ST_SQRT,
    ST_CAP,
    ST_DEN,
    ST_MULC,
    ST_LOADD,
    ST_DIV,
    ST_SAT,
    ST_STORE,
    ST_EMIT
  } st_t;

  function automatic logic [16:0] mag17(input logic [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    return v[15] ? (~e + 17'd1) : e;
  endfunction

endpackage

// ----- rtl/core/thumbstick_radial_deadzone.sv -----
// ----------------------------------------------------------------------------
// thumbstick_radial_deadzone
// Radial deadzone and Q1.15 rescaling of both thumbsticks of each gamepad,
// with change detection against the last stored stick position.
// ----------------------------------------------------------------------------
// One input beat is handled at a time; in_tready is high only while the block
// waits for a beat. Per stick the sample is squared and compared with the
// deadzone, and if the stick is outside the deadzone a further 24 square-root
// steps and two axis divisions (16 quotient bits each) follow on one shared
// 56-bit subtract-compare unit, all fed by one shared 24x17 multiplier. A beat
// for a pad at or above PAD_COUNT is dropped. A result beat waits in the output
// register, so a new input beat may be taken while it is still pending; a
// further result holds the block until the pending beat has been taken.
// ----------------------------------------------------------------------------
module thumbstick_radial_deadzone
  import tsrd_pkg::*;
#(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pad[1:0], left_x[17:2], left_y[33:18], right_x[49:34], right_y[65:50]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pad_out[1:0], left_out_x[17:2], left_out_y[33:18],
  // right_out_x[49:34], right_out_y[65:50]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DZ_W-1:0]       cfg_wr_data
);

  localparam int IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  st_t state_r, state_nxt;

  logic [DZ_W-1:0] left_dz_r, right_dz_r;
  logic [31:0]     left_last_r  [PAD_COUNT];
  logic [31:0]     right_last_r [PAD_COUNT];

  logic [PAD_W-1:0]  pad_r, pad_nxt;
  logic [AXIS_W-1:0] lx_r, lx_nxt, ly_r, ly_nxt, rx_r, rx_nxt, ry_r, ry_nxt;
  logic              stk_r, stk_nxt, axs_r, axs_nxt;
  logic              inside_r, inside_nxt, chg_r, chg_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [31:0]       s_r, s_nxt;
  logic [40:0]       prod_r, prod_nxt;
  logic [47:0]       res_r, res_nxt, bit_r, bit_nxt;
  logic [55:0]       rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [15:0]       q_r, q_nxt;
  logic [23:0]       diff_r, diff_nxt;
  logic [38:0]       den_r, den_nxt;
  logic [3:0][15:0]  obuf_r, obuf_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [PAD_W-1:0]  in_pad;
  logic              in_hs;
  logic [IDX_W-1:0]  idx;
  logic [AXIS_W-1:0] cur_x, cur_y, cur_c;
  logic [DZ_W-1:0]   cur_dz;
  logic [31:0]       last_cur, packed_cur;
  logic [23:0]       mul_a, cap, dz256;
  logic [16:0]       mul_b;
  logic [55:0]       sub_a, sub_b;
  logic [56:0]       sub_d;
  logic              sub_ge;
  logic [15:0]       sat_q;
  logic              we_l, we_r;
  logic [31:0]       st_wdata;

  assign in_pad = in_tdata[1:0];
  assign in_hs  = in_tvalid & in_tready;
  assign idx    = IDX_W'(pad_r);

  assign cur_x    = stk_r ? rx_r : lx_r;
  assign cur_y    = stk_r ? ry_r : ly_r;
  assign cur_c    = axs_r ? cur_y : cur_x;
  assign cur_dz   = stk_r ? right_dz_r : left_dz_r;
  assign last_cur = stk_r ? right_last_r[idx] : left_last_r[idx];
  assign packed_cur = inside_r ? 32'd0 : {cur_y, cur_x};

  assign dz256 = {1'b0, cur_dz, 8'd0};
  assign cap   = (res_r[23:0] < CAP_MAX) ? res_r[23:0] : CAP_MAX;

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = ~sub_d[56];

  assign prod_nxt = 41'(mul_a) * 41'(mul_b);

  always_comb begin
    state_nxt      = state_r;
    pad_nxt        = pad_r;
    lx_nxt         = lx_r;
    ly_nxt         = ly_r;
    rx_nxt         = rx_r;
    ry_nxt         = ry_r;
    stk_nxt        = stk_r;
    axs_nxt        = axs_r;
    inside_nxt     = inside_r;
    chg_nxt        = chg_r;
    cnt_nxt        = cnt_r;
    s_nxt          = s_r;
    res_nxt        = res_r;
    bit_nxt        = bit_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    q_nxt          = q_r;
    diff_nxt       = diff_r;
    den_nxt        = den_r;
    obuf_nxt       = obuf_r;
    out_data_nxt   = out_data_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    in_tready      = 1'b0;
    mul_a          = 24'd0;
    mul_b          = 17'd0;
    sub_a          = rem_r;
    sub_b          = dvs_r;
    sat_q          = 16'd0;
    we_l           = 1'b0;
    we_r           = 1'b0;
    st_wdata       = 32'd0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_hs) begin
          pad_nxt = in_pad;
          lx_nxt  = in_tdata[17:2];
          ly_nxt  = in_tdata[33:18];
          rx_nxt  = in_tdata[49:34];
          ry_nxt  = in_tdata[65:50];
          stk_nxt = 1'b0;
          chg_nxt = 1'b0;
          if (32'(in_pad) >= 32'(PAD_COUNT)) begin
            state_nxt = ST_IDLE;
          end else if (in_tuser) begin
            state_nxt = ST_DISC;
          end else begin
            state_nxt = ST_SQ_X;
          end
        end
      end
      ST_DISC: begin
        if (left_last_r[idx] != 32'd0 || right_last_r[idx] != 32'd0) begin
          we_l      = 1'b1;
          we_r      = 1'b1;
          obuf_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SQ_X: begin
        mul_a     = 24'(mag17(cur_x));
        mul_b     = mag17(cur_x);
        state_nxt = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        s_nxt     = prod_r[31:0];
        mul_a     = 24'(mag17(cur_y));
        mul_b     = mag17(cur_y);
        state_nxt = ST_SQ_DZ;
      end
      ST_SQ_DZ: begin
        s_nxt     = s_r + prod_r[31:0];
        mul_a     = 24'(cur_dz);
        mul_b     = 17'(cur_dz);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        inside_nxt = (s_r <= prod_r[31:0]);
        if (s_r <= prod_r[31:0]) begin
          obuf_nxt[{stk_r, 1'b0}] = 16'd0;
          obuf_nxt[{stk_r, 1'b1}] = 16'd0;
          state_nxt = ST_STORE;
        end else begin
          rem_nxt   = {8'd0, s_r, 16'd0};
          res_nxt   = 48'd0;
          bit_nxt   = ROOT_BIT0;
          cnt_nxt   = 5'd23;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sub_b = {8'd0, res_r + bit_r};
        if (sub_ge) begin
          rem_nxt = sub_d[55:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = ST_CAP;
        end
      end
      ST_CAP: begin
        axs_nxt = 1'b0;
        mul_a   = res_r[23:0];
        mul_b   = 17'(FULL_SCALE - cur_dz);
        if (cap <= dz256) begin
          obuf_nxt[{stk_r, 1'b0}] = 16'd0;
          obuf_nxt[{stk_r, 1'b1}] = 16'd0;
          state_nxt = ST_STORE;
        end else begin
          diff_nxt  = cap - dz256;
          state_nxt = ST_DEN;
        end
      end
      ST_DEN: begin
        den_nxt   = prod_r[38:0];
        state_nxt = ST_MULC;
      end
      ST_MULC: begin
        mul_a     = diff_r;
        mul_b     = mag17(cur_c);
        state_nxt = ST_LOADD;
      end
      ST_LOADD: begin
        rem_nxt   = {prod_r, 15'd0};
        dvs_nxt   = {2'd0, den_r, 15'd0};
        q_nxt     = 16'd0;
        cnt_nxt   = 5'd15;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sub_ge) begin
          rem_nxt = sub_d[55:0];
        end
        q_nxt   = {q_r[14:0], sub_ge};
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        if (cur_c[15]) begin
          sat_q = (q_r > 16'd32768) ? 16'd32768 : q_r;
          obuf_nxt[{stk_r, axs_r}] = 16'd0 - sat_q;
        end else begin
          sat_q = (q_r > 16'd32767) ? 16'd32767 : q_r;
          obuf_nxt[{stk_r, axs_r}] = sat_q;
        end
        if (!axs_r) begin
          axs_nxt   = 1'b1;
          state_nxt = ST_MULC;
        end else begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        we_l     = ~stk_r;
        we_r     = stk_r;
        st_wdata = packed_cur;
        chg_nxt  = chg_r | (last_cur != packed_cur);
        if (!stk_r) begin
          stk_nxt   = 1'b1;
          state_nxt = ST_SQ_X;
        end else if (chg_r || last_cur != packed_cur) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt   = {6'd0, obuf_r, pad_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pad_r      <= pad_nxt;
    lx_r       <= lx_nxt;
    ly_r       <= ly_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    stk_r      <= stk_nxt;
    axs_r      <= axs_nxt;
    inside_r   <= inside_nxt;
    chg_r      <= chg_nxt;
    cnt_r      <= cnt_nxt;
    s_r        <= s_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    bit_r      <= bit_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    q_r        <= q_nxt;
    diff_r     <= diff_nxt;
    den_r      <= den_nxt;
    obuf_r     <= obuf_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_dz_r  <= LEFT_DZ_RST;
      right_dz_r <= RIGHT_DZ_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_LEFT_DZ:  left_dz_r  <= cfg_wr_data;
        REG_RIGHT_DZ: right_dz_r <= cfg_wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
        left_last_r[i]  <= 32'd0;
        right_last_r[i] <= 32'd0;
      end
    end else begin
      if (we_l) begin
        left_last_r[idx] <= st_wdata;
      end
      if (we_r) begin
        right_last_r[idx] <= st_wdata;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CAP |->
      (64'(res_r[23:0]) * 64'(res_r[23:0]) <= {16'd0, s_r, 16'd0}) &&
      ((64'(res_r[23:0]) + 64'd1) * (64'(res_r[23:0]) + 64'd1) > {16'd0, s_r, 16'd0}))
    else $error("square root out of range");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SAT |-> q_r <= 16'd32768)
    else $error("scaled axis quotient above full scale");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SAT |-> rem_r < {17'd0, den_r})
    else $error("division remainder not below divisor");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_EMIT))
    else $error("result beat raised outside emit");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: thumbstick_radial_deadzone
// Streams stick polls and disconnects for all pads through the block under
// several deadzone settings. A model of the block kept here works out each
// move result, and the monitor compares every result beat with it.
// ----------------------------------------------------------------------------
module testbench
  import tsrd_pkg::*;
();

  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic        mode;
    logic [1:0]  pad;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
  } poll_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
  } move_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [DZ_W-1:0]       cfg_wr_data = '0;

  poll_t       pending_polls[$];
  move_t       move_due[$];
  poll_t       cur_poll;
  poll_t       last_sent[4];
  logic [31:0] left_mem[4];
  logic [31:0] right_mem[4];
  logic [DZ_W-1:0] dz_left = LEFT_DZ_RST;
  logic [DZ_W-1:0] dz_right = RIGHT_DZ_RST;
  logic        steady = 1'b0;
  int          errors = 0;
  int          n_polls = 0;
  int          n_disc = 0;
  int          n_moves = 0;
  int          n_settings = 1;

  thumbstick_radial_deadzone u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] scale_axis(input logic signed [15:0] c,
                                             input longint unsigned m,
                                             input logic [DZ_W-1:0] dz);
    longint unsigned cap, dzs, mag, num, den, q;
    int ci;
    if (dz == FULL_SCALE || m == 0) return '0;
    dzs = dz;
    dzs = dzs * 256;
    cap = (m < 64'h7FFF00) ? m : 64'h7FFF00;
    if (cap <= dzs) return '0;
    ci = c;
    mag = (ci < 0) ? -ci : ci;
    num = 64'd32768 * mag * (cap - dzs);
    den = m * (64'd32767 - dz);
    q = num / den;
    if (ci < 0) begin
      if (q > 32768) q = 32768;
      return 16'(64'd65536 - q);
    end
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  function automatic logic track_stick(input logic signed [15:0] x,
                                       input logic signed [15:0] y,
                                       input logic [DZ_W-1:0] dz,
                                       inout logic [31:0] mem,
                                       output logic [15:0] ox,
                                       output logic [15:0] oy);
    longint unsigned s, lim, m;
    logic [31:0] pos;
    s = longint'(int'(x) * int'(x)) + longint'(int'(y) * int'(y));
    lim = dz;
    lim = lim * lim;
    ox = '0;
    oy = '0;
    pos = '0;
    if (s > lim) begin
      m = root_floor(s << 16);
      ox = scale_axis(x, m, dz);
      oy = scale_axis(y, m, dz);
      pos = {y, x};
    end
    if (mem != pos) begin
      mem = pos;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic predict_move(input poll_t p, output move_t mv);
    logic cl, cr;
    logic [31:0] lm, rm;
    mv = '0;
    mv.pad = p.pad;
    if (p.mode) begin
      if (left_mem[p.pad] == 0 && right_mem[p.pad] == 0) return 1'b0;
      left_mem[p.pad] = '0;
      right_mem[p.pad] = '0;
      return 1'b1;
    end
    lm = left_mem[p.pad];
    rm = right_mem[p.pad];
    cl = track_stick(p.lx, p.ly, dz_left, lm, mv.lx, mv.ly);
    cr = track_stick(p.rx, p.ry, dz_right, rm, mv.rx, mv.ry);
    left_mem[p.pad] = lm;
    right_mem[p.pad] = rm;
    return cl || cr;
  endfunction

  function automatic void pick_stick(input logic [DZ_W-1:0] dz,
                                     output logic [15:0] x, output logic [15:0] y);
    int a, b;
    case ($urandom_range(0, 5))
      0, 1: begin
        x = 16'($urandom);
        y = 16'($urandom);
        return;
      end
      2: begin
        a = int'(dz) + int'($urandom_range(0, 16)) - 8;
        b = int'($urandom_range(0, 3));
      end
      3: begin
        a = ((int'(dz) * 46341) >>> 16) + int'($urandom_range(0, 8)) - 4;
        b = a + int'($urandom_range(0, 2)) - 1;
      end
      4: begin
        x = $urandom_range(0, 1) ? 16'h7FFF : ($urandom_range(0, 1) ? 16'h8000 : 16'h0);
        y = $urandom_range(0, 1) ? 16'h8000 : ($urandom_range(0, 1) ? 16'h7FFF : 16'($urandom));
        return;
      end
      default: begin
        a = int'($urandom_range(0, 300));
        b = int'($urandom_range(0, 300));
      end
    endcase
    if (a > 32767) a = 32767;
    if (a < 0) a = 0;
    if (b > 32767) b = 32767;
    if (b < 0) b = 0;
    if ($urandom_range(0, 1)) a = -a;
    if ($urandom_range(0, 1)) b = -b;
    if ($urandom_range(0, 1)) begin
      x = 16'(a);
      y = 16'(b);
    end else begin
      x = 16'(b);
      y = 16'(a);
    end
  endfunction

  function automatic poll_t random_poll();
    poll_t p;
    int roll;
    p.pad = 2'($urandom_range(0, 3));
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      p.mode = 1'b1;
      {p.lx, p.ly, p.rx, p.ry} = {$urandom, $urandom};
      return p;
    end
    p = last_sent[p.pad];
    p.mode = 1'b0;
    if (roll >= 25) begin
      if ($urandom_range(0, 9) >= 3) pick_stick(dz_left, p.lx, p.ly);
      if ($urandom_range(0, 9) >= 3) pick_stick(dz_right, p.rx, p.ry);
    end
    last_sent[p.pad] = p;
    return p;
  endfunction

  task automatic add_poll(input logic mode, input logic [1:0] pad,
                          input int lx, input int ly, input int rx, input int ry);
    poll_t p;
    p = '{mode, pad, 16'(lx), 16'(ly), 16'(rx), 16'(ry)};
    if (!mode) last_sent[pad] = p;
    pending_polls.push_back(p);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DZ_W-1:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_LEFT_DZ) dz_left = val;
    else dz_right = val;
  endtask

  task automatic set_deadzones(input logic [DZ_W-1:0] left, input logic [DZ_W-1:0] right);
    write_reg(REG_LEFT_DZ, left);
    write_reg(REG_RIGHT_DZ, right);
    n_settings++;
  endtask

  task automatic run_phase(input int count);
    repeat (count) pending_polls.push_back(random_poll());
    while (pending_polls.size() != 0 || in_tvalid || move_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // drive input beats, predicting each one as it is taken
  always @(posedge clk) begin : drive
    move_t mv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (predict_move(cur_poll, mv)) move_due.push_back(mv);
        if (cur_poll.mode) n_disc++;
        else n_polls++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_polls.size() != 0 && (steady || $urandom_range(0, 99) >= 6)) begin
          cur_poll = pending_polls.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, cur_poll.ry, cur_poll.rx, cur_poll.ly, cur_poll.lx, cur_poll.pad};
          in_tuser  <= cur_poll.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // check result beats against the oldest predicted move
  always @(posedge clk) begin : watch
    move_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[17:2], out_tdata[33:18],
               out_tdata[49:34], out_tdata[65:50]};
        if (move_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected move beat: pad %0d L(%0d,%0d) R(%0d,%0d)", got.pad,
                     $signed(got.lx), $signed(got.ly), $signed(got.rx), $signed(got.ry));
        end else begin
          want = move_due.pop_front();
          n_moves++;
          if (got.pad != want.pad || got.lx != want.lx || got.ly != want.ly ||
              got.rx != want.rx || got.ry != want.ry) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"move mismatch: expected pad %0d L(%0d,%0d) R(%0d,%0d), ",
                        "got pad %0d L(%0d,%0d) R(%0d,%0d)"},
                       want.pad, $signed(want.lx), $signed(want.ly),
                       $signed(want.rx), $signed(want.ry), got.pad, $signed(got.lx),
                       $signed(got.ly), $signed(got.rx), $signed(got.ry));
          end
        end
      end
      out_tready <= steady || $urandom_range(0, 99) >= 6;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) begin
      left_mem[i] = '0;
      right_mem[i] = '0;
      last_sent[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    add_poll(0, 0, 0, 0, 0, 0);
    add_poll(0, 0, 32767, 0, 0, -32768);
    add_poll(0, 0, 32767, 0, 0, -32768);
    add_poll(0, 0, -32768, -32768, -32768, -32768);
    add_poll(0, 1, 32767, 32767, -32768, 32767);
    add_poll(0, 1, 7850, 0, 0, 8690);
    add_poll(0, 1, 7849, 0, 0, 8689);
    add_poll(0, 1, 0, -7850, -8690, 0);
    add_poll(0, 2, -1, -1, 1, 1);
    add_poll(0, 2, 5550, 5551, -6144, 6144);
    add_poll(0, 2, -5550, 5551, 6144, -6145);
    add_poll(1, 0, 0, 0, 0, 0);
    add_poll(1, 0, -1, -1, -1, -1);
    add_poll(1, 3, 12345, -12345, 32767, -32768);
    add_poll(0, 3, 20000, -20000, 100, 100);
    add_poll(0, 3, 20000, -20000, 100, 100);
    add_poll(0, 3, 100, 100, 100, 100);
    add_poll(0, 3, 100, 100, 30000, -30000);
    add_poll(1, 3, -32768, 32767, 21845, -21846);
    add_poll(1, 2, 0, 0, 0, 0);
    add_poll(0, 2, 32767, -32768, 32767, -32768);
    run_phase(100);

    set_deadzones('0, '0);
    run_phase(120);

    set_deadzones(FULL_SCALE, 15'd32766);
    run_phase(120);

    steady = 1'b1;
    set_deadzones(15'd32766, FULL_SCALE);
    run_phase(120);
    steady = 1'b0;

    set_deadzones(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
    run_phase(120);

    set_deadzones(15'd1, 15'd16000);
    run_phase(120);

    errors += move_due.size();
    $display("Sent %0d stick samples and %0d disconnects across %0d deadzone settings;",
             n_polls, n_disc, n_settings);
    $display("%0d move beats compared, %0d failures.", n_moves, errors);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #(8 * LIMIT_CYCLES);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("testbench failed");
    $finish;
  end

endmodule
